// File: rtl/erh_pkg.sv
// Package: shared types and constants for the R-peak / HRV block.
package erh_pkg;

    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_THRESHOLD = 3'd0,
        REG_DECAY     = 3'd1,
        REG_FLOOR     = 3'd2,
        REG_DECAY_INT = 3'd3,
        REG_RR_MIN    = 3'd4,
        REG_RR_MAX    = 3'd5,
        REG_NN_LIMIT  = 3'd6
    } reg_idx_t;

    localparam logic [15:0] THRESH_RST    = 16'd39322;
    localparam logic [15:0] DECAY_RST     = 16'd64881;
    localparam logic [17:0] FLOOR_RST     = 18'd655;
    localparam logic [15:0] DECAY_INT_RST = 16'd200;
    localparam logic [15:0] RR_MIN_RST    = 16'd333;
    localparam logic [15:0] RR_MAX_RST    = 16'd1500;
    localparam logic [15:0] NN_LIMIT_RST  = 16'd50;

    localparam logic [22:0] HR_NUMER = 23'd6000000;

    // Input beat payload
    typedef struct packed {
        logic signed [17:0] sample;
        logic [31:0]        timestamp_ms;
    } in_item_t;

    // Result beat payload
    typedef struct packed {
        logic        beat;
        logic        rr_accepted;
        logic [15:0] rr_last_ms;
        logic [15:0] heart_rate_x100;
        logic [15:0] rmssd_x16;
        logic [13:0] pnn50_x100;
        logic        hrv_valid;
        logic [17:0] running_peak;
    } out_item_t;

    // Register write payload
    typedef struct packed {
        logic [CFG_IDX_W-1:0] index;
        logic [31:0]          data;
    } cfg_item_t;

    // Front-to-back queue entry
    typedef struct packed {
        logic        beat;
        logic        has_rr;
        logic [15:0] rr;
        logic [17:0] peak;
    } evt_t;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        B_IDLE,
        B_CHECK,
        B_DIV,
        B_WALK,
        B_MEAN,
        B_SQRT,
        B_PNN,
        B_OUT
    } back_state_t;

endpackage

// File: rtl/erh_if.sv
// Interfaces: valid/ready stream channel.
interface erh_stream_if #(parameter int W = 8);
    logic         valid;
    logic         ready;
    logic [W-1:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// File: rtl/ecg_rpeak_rr_hrv.sv
// Top level: R-peak detector with RR interval ring and HRV statistics.
//
// Channels: in_ch carries {sample, timestamp_ms}; out_ch carries one result
// beat for every input beat; cfg_ch writes the seven registers by index
// (indexes beyond the list are dropped). The user must write them only while
// the block is idle; the block itself does not enforce this. A sample
// without an accepted interval passes the front-end register, the queue and
// the back-end check and output states. A sample that stores an interval
// runs the back-end sequencer: a division for heart rate, a walk of one ring
// entry per cycle, a division for the mean square (after a step that loads
// it), a square root and a division for pNN50. These share one restoring
// divide/root unit. The front end takes a new sample only once it has pushed
// the event of the last one, and hands events to the back end through a
// four-entry queue, so ordinary samples stream while a long computation
// drains. Reset clears the control and result state at once; ring entries
// carry valid bits so no clearing pass is needed. A stalled receiver holds
// the result register, then the queue fills and in_ch.ready drops.
module ecg_rpeak_rr_hrv
    import erh_pkg::*;
#(
    parameter int RING_DEPTH = 20
)
(
    input logic   clk,
    input logic   rst_n,
    erh_stream_if.sink   in_ch,
    erh_stream_if.source out_ch,
    erh_stream_if.sink   cfg_ch
);
    logic [15:0] thr_reg, dec_reg, dint_reg, rmin_reg, rmax_reg, nn_reg;
    logic [17:0] flr_reg;
    cfg_item_t   cfg;
    in_item_t    in_item;
    out_item_t   out_item;
    logic        q_push, q_full, q_pop, q_empty;
    evt_t        q_in, q_head;

    assign cfg          = cfg_ch.data;
    assign cfg_ch.ready = 1'b1;
    assign in_item      = in_ch.data;
    assign out_ch.data  = out_item;

    // register file
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            thr_reg  <= THRESH_RST;
            dec_reg  <= DECAY_RST;
            flr_reg  <= FLOOR_RST;
            dint_reg <= DECAY_INT_RST;
            rmin_reg <= RR_MIN_RST;
            rmax_reg <= RR_MAX_RST;
            nn_reg   <= NN_LIMIT_RST;
        end else if (cfg_ch.valid) begin
            case (cfg.index)
                REG_THRESHOLD: thr_reg  <= cfg.data[15:0];
                REG_DECAY:     dec_reg  <= cfg.data[15:0];
                REG_FLOOR:     flr_reg  <= cfg.data[17:0];
                REG_DECAY_INT: dint_reg <= cfg.data[15:0];
                REG_RR_MIN:    rmin_reg <= cfg.data[15:0];
                REG_RR_MAX:    rmax_reg <= cfg.data[15:0];
                REG_NN_LIMIT:  nn_reg   <= cfg.data[15:0];
                default: ;
            endcase
        end
    end

    erh_front u_front (
        .clk, .rst_n,
        .in_valid(in_ch.valid), .in_ready(in_ch.ready), .in_item,
        .threshold_fraction(thr_reg), .decay_fraction(dec_reg),
        .floor_level(flr_reg), .decay_interval_ms(dint_reg),
        .q_full, .q_push, .q_evt(q_in)
    );

    erh_queue #(.DEPTH(4)) u_queue (
        .clk, .rst_n, .push(q_push), .push_data(q_in), .full(q_full),
        .pop(q_pop), .empty(q_empty), .head(q_head)
    );

    erh_back #(.RING_DEPTH(RING_DEPTH)) u_back (
        .clk, .rst_n, .q_empty, .q_head, .q_pop,
        .rr_min_ms(rmin_reg), .rr_max_ms(rmax_reg), .nn_limit_ms(nn_reg),
        .out_valid(out_ch.valid), .out_ready(out_ch.ready), .out_item
    );

    // an accepted interval always comes with a beat
    a_acc_beat: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> (!out_item.rr_accepted || out_item.beat))
        else $error("interval without beat");

    // pNN50 never exceeds 100 percent
    a_pnn_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_ch.valid |-> out_item.pnn50_x100 <= 14'd10000)
        else $error("pnn50 out of range");

    // no pop from an empty queue
    a_q_pop: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue underflow");
endmodule

// File: rtl/erh_front.sv
// Front end: running peak, decay, threshold crossing and raw interval forming.
module erh_front
    import erh_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  in_item_t    in_item,
    input  logic [15:0] threshold_fraction,
    input  logic [15:0] decay_fraction,
    input  logic [17:0] floor_level,
    input  logic [15:0] decay_interval_ms,
    input  logic        q_full,
    output logic        q_push,
    output evt_t        q_evt
);
    // two stages: stage A updates peak, stage B does threshold compare
    logic        busy_reg, busy_next;
    logic [17:0] peak_reg, peak_next;
    logic [31:0] decay_time_reg, decay_time_next;
    logic        was_above_reg, was_above_next;
    logic        seen_reg, seen_next;
    logic [31:0] peak_time_reg, peak_time_next;
    logic [17:0] mag_reg, mag_next;
    logic [31:0] ts_reg, ts_next;

    logic [17:0] raw;
    logic [17:0] mag;
    logic [17:0] pk1;
    logic [31:0] dt;
    logic [33:0] prod_d;
    logic [17:0] pk2;
    logic [33:0] lhs, rhs;
    logic        above;
    logic [31:0] rr32;

    assign in_ready = !busy_reg;

    always_comb
    begin
        raw    = in_item.sample;
        mag    = raw[17] ? 18'((19'h40000 - {1'b0, raw})) : raw;
        pk1    = (mag > peak_reg) ? mag : peak_reg;
        dt     = in_item.timestamp_ms - decay_time_reg;
        prod_d = 34'(pk1) * 34'(decay_fraction);
        pk2    = prod_d[33:16];
        if (pk2 < floor_level)
            pk2 = floor_level;
        lhs    = {mag_reg, 16'd0};
        rhs    = 34'(peak_reg) * 34'(threshold_fraction);
        above  = lhs > rhs;
        rr32   = ts_reg - peak_time_reg;
    end

    always_comb
    begin
        busy_next       = busy_reg;
        peak_next       = peak_reg;
        decay_time_next = decay_time_reg;
        was_above_next  = was_above_reg;
        seen_next       = seen_reg;
        peak_time_next  = peak_time_reg;
        mag_next        = mag_reg;
        ts_next         = ts_reg;
        q_push          = 1'b0;
        q_evt.beat      = 1'b0;
        q_evt.has_rr    = 1'b0;
        q_evt.rr        = rr32[15:0];
        q_evt.peak      = peak_reg;
        if (!busy_reg) begin
            if (in_valid) begin
                busy_next = 1'b1;
                mag_next  = mag;
                ts_next   = in_item.timestamp_ms;
                peak_next = pk1;
                if (dt > 32'(decay_interval_ms)) begin
                    peak_next       = pk2;
                    decay_time_next = in_item.timestamp_ms;
                end
            end
        end else if (!q_full) begin
            q_push         = 1'b1;
            busy_next      = 1'b0;
            was_above_next = above;
            if (above && !was_above_reg) begin
                q_evt.beat     = 1'b1;
                q_evt.has_rr   = seen_reg && (rr32[31:16] == 16'd0);
                seen_next      = 1'b1;
                peak_time_next = ts_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            busy_reg       <= 1'b0;
            peak_reg       <= '0;
            decay_time_reg <= '0;
            was_above_reg  <= 1'b0;
            seen_reg       <= 1'b0;
            peak_time_reg  <= '0;
        end else begin
            busy_reg       <= busy_next;
            peak_reg       <= peak_next;
            decay_time_reg <= decay_time_next;
            was_above_reg  <= was_above_next;
            seen_reg       <= seen_next;
            peak_time_reg  <= peak_time_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mag_reg <= mag_next;
        ts_reg  <= ts_next;
    end
endmodule

// File: rtl/erh_queue.sv
// Event queue: small FIFO between front and back ends.
module erh_queue
    import erh_pkg::*;
#(
    parameter int DEPTH = 4
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  evt_t push_data,
    output logic full,
    input  logic pop,
    output logic empty,
    output evt_t head
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    evt_t                 mem_reg [DEPTH];
    logic [AW-1:0]        wp_reg, rp_reg;
    logic [$clog2(DEPTH+1)-1:0] cnt_reg;

    assign full  = cnt_reg == ($clog2(DEPTH+1))'(DEPTH);
    assign empty = cnt_reg == '0;
    assign head  = mem_reg[rp_reg];

    always_ff @(posedge clk)
    begin
        if (push && !full)
            mem_reg[wp_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg  <= '0;
            rp_reg  <= '0;
            cnt_reg <= '0;
        end else begin
            if (push && !full)
                wp_reg <= (wp_reg == AW'(DEPTH - 1)) ? '0 : wp_reg + 1'b1;
            if (pop && !empty)
                rp_reg <= (rp_reg == AW'(DEPTH - 1)) ? '0 : rp_reg + 1'b1;
            cnt_reg <= cnt_reg + ($clog2(DEPTH+1))'(push && !full)
                               - ($clog2(DEPTH+1))'(pop && !empty);
        end
    end
endmodule

// File: rtl/erh_back.sv
// Back end: interval checks, ring store, heart rate, RMSSD and pNN50.
module erh_back
    import erh_pkg::*;
#(
    parameter int RING_DEPTH = 20
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        q_empty,
    input  evt_t        q_head,
    output logic        q_pop,
    input  logic [15:0] rr_min_ms,
    input  logic [15:0] rr_max_ms,
    input  logic [15:0] nn_limit_ms,
    output logic        out_valid,
    input  logic        out_ready,
    output out_item_t   out_item
);
    localparam int PW = $clog2(RING_DEPTH);
    localparam int FW = $clog2(RING_DEPTH + 1);
    localparam int SW = 32 + FW + 8;

    back_state_t state_reg, state_next;

    logic [15:0]   ring_mem [RING_DEPTH];
    logic [RING_DEPTH-1:0] vld_reg;
    logic [PW-1:0] wpos_reg;
    logic [FW-1:0] fill_reg;
    logic [15:0]   last_reg, rate_reg, rmssd_reg;
    logic [13:0]   pnn_reg;
    logic          hrv_reg;
    logic          acc_reg;
    evt_t          evt_reg;
    logic          ovalid_reg;
    out_item_t     oitem_reg;

    // shared iterative unit: restoring divider / bit-pair square root
    logic [SW-1:0] num_reg;
    logic [SW-1:0] quo_reg;
    logic [SW-1:0] rem_reg;
    logic [22:0]   den_reg;
    logic [6:0]    cnt_reg;
    logic [PW-1:0] rd_reg;
    logic [FW-1:0] k_reg;
    logic [15:0]   a_reg;
    logic [SW-1:0] sum_reg;
    logic [FW-1:0] nnc_reg;
    logic [31:0]   sq_reg;
    logic          sqv_reg;

    logic [15:0]   rd_data;
    logic [15:0]   dif;
    logic [SW:0]   trial;
    logic [SW+1:0] rtrial;
    logic          ratio_bad;

    // previous entry read (valid bit gives reset value zero)
    assign rd_data = vld_reg[rd_reg] ? ring_mem[rd_reg] : 16'd0;
    assign dif     = (rd_data > a_reg) ? rd_data - a_reg : a_reg - rd_data;
    assign trial   = {rem_reg, num_reg[SW-1]} - {{(SW-22){1'b0}}, den_reg};

    // ratio test against previous interval
    assign ratio_bad = (fill_reg != '0) &&
                       (((18'(evt_reg.rr) << 2) < 18'(rd_data)) ||
                        (18'(evt_reg.rr) > 18'(rd_data) * 18'd3));

    assign q_pop     = (state_reg == B_IDLE) && !q_empty && !ovalid_reg;
    assign out_valid = ovalid_reg;
    assign out_item  = oitem_reg;

    function automatic logic [PW-1:0] wrap_inc(input logic [PW-1:0] p);
        wrap_inc = (p == PW'(RING_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    function automatic logic [PW-1:0] wrap_dec(input logic [PW-1:0] p);
        wrap_dec = (p == '0) ? PW'(RING_DEPTH - 1) : p - 1'b1;
    endfunction

    // sqrt step: one result bit per cycle on remainder/root
    always_comb
    begin
        rtrial = {rem_reg, num_reg[SW-1:SW-2]} - {quo_reg, 2'b01};
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            B_IDLE:  if (q_pop) state_next = B_CHECK;
            B_CHECK: state_next = B_OUT;
            B_DIV:   if (cnt_reg == 7'd0) state_next = B_WALK;
            B_WALK:  if (k_reg == FW'(1)) state_next = B_MEAN;
            B_MEAN:  if (cnt_reg == 7'd0) state_next = B_SQRT;
            B_SQRT:  if (cnt_reg == 7'd0) state_next = B_PNN;
            B_PNN:   if (cnt_reg == 7'd0) state_next = B_OUT;
            B_OUT:   state_next = B_IDLE;
            default: state_next = B_IDLE;
        endcase
        if (state_reg == B_CHECK && acc_reg && !ratio_bad)
            state_next = B_DIV;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= B_IDLE;
        else
            state_reg <= state_next;
    end

    // ring write at accept; read address driven by the sequencer
    always_ff @(posedge clk)
    begin
        if (state_reg == B_CHECK && acc_reg && !ratio_bad)
            ring_mem[wpos_reg] <= evt_reg.rr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            vld_reg    <= '0;
            wpos_reg   <= '0;
            fill_reg   <= '0;
            last_reg   <= '0;
            rate_reg   <= '0;
            rmssd_reg  <= '0;
            pnn_reg    <= '0;
            hrv_reg    <= 1'b0;
            ovalid_reg <= 1'b0;
            acc_reg    <= 1'b0;
            rd_reg     <= '0;
            evt_reg    <= '0;
            oitem_reg  <= '0;
            num_reg    <= '0;
            quo_reg    <= '0;
            rem_reg    <= '0;
            den_reg    <= '0;
            cnt_reg    <= '0;
            k_reg      <= '0;
            a_reg      <= '0;
            sum_reg    <= '0;
            nnc_reg    <= '0;
            sq_reg     <= '0;
            sqv_reg    <= 1'b0;
        end else begin
            if (ovalid_reg && out_ready)
                ovalid_reg <= 1'b0;
            unique case (state_reg)
                B_IDLE:
                begin
                    if (q_pop) begin
                        evt_reg <= q_head;
                        acc_reg <= q_head.has_rr && q_head.rr >= rr_min_ms
                                   && q_head.rr <= rr_max_ms;
                        rd_reg  <= wrap_dec(wpos_reg);
                    end
                end
                B_CHECK:
                begin
                    if (acc_reg && ratio_bad)
                        acc_reg <= 1'b0;
                    if (acc_reg && !ratio_bad) begin
                        vld_reg[wpos_reg] <= 1'b1;
                        wpos_reg <= wrap_inc(wpos_reg);
                        if (fill_reg != FW'(RING_DEPTH))
                            fill_reg <= fill_reg + 1'b1;
                        last_reg <= evt_reg.rr;
                        num_reg  <= SW'(HR_NUMER);
                        den_reg  <= 23'(evt_reg.rr);
                        rem_reg  <= '0;
                        quo_reg  <= '0;
                        cnt_reg  <= 7'(SW - 1);
                    end
                end
                B_DIV:
                begin
                    num_reg <= num_reg << 1;
                    if (!trial[SW]) begin
                        rem_reg <= trial[SW-1:0];
                        quo_reg <= {quo_reg[SW-2:0], 1'b1};
                    end else begin
                        rem_reg <= {rem_reg[SW-2:0], num_reg[SW-1]};
                        quo_reg <= {quo_reg[SW-2:0], 1'b0};
                    end
                    if (cnt_reg == 7'd0) begin
                        if (den_reg == '0 || quo_reg[SW-2:15] != '0)
                            rate_reg <= 16'hFFFF;
                        else
                            rate_reg <= {quo_reg[14:0], !trial[SW]};
                        // set up the walk: newest entry backward, fill-1 differences
                        k_reg   <= fill_reg - 1'b1;
                        rd_reg  <= wrap_dec(wpos_reg);
                        a_reg   <= 16'd0;
                        sum_reg <= '0;
                        nnc_reg <= '0;
                        sqv_reg <= 1'b0;
                    end else begin
                        cnt_reg <= cnt_reg - 1'b1;
                    end
                end
                B_WALK:
                begin
                    // one entry per cycle; first read only primes a_reg
                    if (fill_reg < FW'(4)) begin
                        k_reg <= FW'(1);
                    end else begin
                        if (sqv_reg) begin
                            sum_reg <= sum_reg + SW'(32'(dif) * 32'(dif));
                            if (dif > nn_limit_ms)
                                nnc_reg <= nnc_reg + 1'b1;
                            k_reg <= k_reg - 1'b1;
                        end
                        sqv_reg <= 1'b1;
                        a_reg   <= rd_data;
                        rd_reg  <= wrap_dec(rd_reg);
                    end
                    if (k_reg == FW'(1) || fill_reg < FW'(4)) begin
                        num_reg <= '0;
                        rem_reg <= '0;
                        quo_reg <= '0;
                        den_reg <= 23'(fill_reg - 1'b1);
                        cnt_reg <= 7'(SW - 1);
                    end
                end
                B_MEAN:
                begin
                    if (fill_reg < FW'(4)) begin
                        cnt_reg <= 7'd0;
                    end else begin
                        if (cnt_reg == 7'(SW - 1) && sqv_reg) begin
                            num_reg <= sum_reg << 8;
                            sqv_reg <= 1'b0;
                        end else begin
                            num_reg <= num_reg << 1;
                            if (!trial[SW]) begin
                                rem_reg <= trial[SW-1:0];
                                quo_reg <= {quo_reg[SW-2:0], 1'b1};
                            end else begin
                                rem_reg <= {rem_reg[SW-2:0], num_reg[SW-1]};
                                quo_reg <= {quo_reg[SW-2:0], 1'b0};
                            end
                            if (cnt_reg != 7'd0)
                                cnt_reg <= cnt_reg - 1'b1;
                            else begin
                                // mean square is below 2^40: shift up one so the
                                // bit pairs line up with the radicand's LSB
                                num_reg <= {quo_reg[SW-3:0], !trial[SW], 1'b0};
                                quo_reg <= '0;
                                rem_reg <= '0;
                                cnt_reg <= 7'(SW / 2 - 1);
                            end
                        end
                    end
                end
                B_SQRT:
                begin
                    if (fill_reg >= FW'(4)) begin
                        num_reg <= num_reg << 2;
                        if (!rtrial[SW+1]) begin
                            rem_reg <= rtrial[SW-1:0];
                            quo_reg <= {quo_reg[SW-2:0], 1'b1};
                        end else begin
                            rem_reg <= {rem_reg[SW-3:0], num_reg[SW-1:SW-2]};
                            quo_reg <= {quo_reg[SW-2:0], 1'b0};
                        end
                    end
                    if (cnt_reg != 7'd0)
                        cnt_reg <= cnt_reg - 1'b1;
                    else begin
                        if (fill_reg >= FW'(4)) begin
                            sq_reg <= 32'({quo_reg[SW-2:0], !rtrial[SW+1]});
                            num_reg <= SW'(nnc_reg) * SW'(10000);
                        end
                        rem_reg <= '0;
                        quo_reg <= '0;
                        cnt_reg <= 7'(SW - 1);
                    end
                end
                B_PNN:
                begin
                    if (fill_reg >= FW'(4)) begin
                        num_reg <= num_reg << 1;
                        if (!trial[SW]) begin
                            rem_reg <= trial[SW-1:0];
                            quo_reg <= {quo_reg[SW-2:0], 1'b1};
                        end else begin
                            rem_reg <= {rem_reg[SW-2:0], num_reg[SW-1]};
                            quo_reg <= {quo_reg[SW-2:0], 1'b0};
                        end
                    end
                    if (cnt_reg != 7'd0)
                        cnt_reg <= cnt_reg - 1'b1;
                    else if (fill_reg >= FW'(4)) begin
                        rmssd_reg <= (sq_reg[31:16] != '0) ? 16'hFFFF : sq_reg[15:0];
                        pnn_reg   <= 14'({quo_reg[SW-2:0], !trial[SW]});
                        hrv_reg   <= 1'b1;
                    end
                end
                B_OUT:
                begin
                    ovalid_reg                <= 1'b1;
                    oitem_reg.beat            <= evt_reg.beat;
                    oitem_reg.rr_accepted     <= acc_reg;
                    oitem_reg.rr_last_ms      <= last_reg;
                    oitem_reg.heart_rate_x100 <= rate_reg;
                    oitem_reg.rmssd_x16       <= rmssd_reg;
                    oitem_reg.pnn50_x100      <= pnn_reg;
                    oitem_reg.hrv_valid       <= hrv_reg;
                    oitem_reg.running_peak    <= evt_reg.peak;
                end
                default: ;
            endcase
        end
    end
endmodule
